// ===== hw/rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants for the two-stack store
// Operation and status codes, field widths and the controller command and
// status bundles.
// ----------------------------------------------------------------------------
package tss_pkg;

	// Field widths of the stream words
	localparam int OP_W     = 3;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 11;

	// Capacity after reset, before clamping to the store depth
	localparam int CAP_RESET = 1024;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH1 = 3'd0,
		OP_PUSH2 = 3'd1,
		OP_POP1  = 3'd2,
		OP_POP2  = 3'd3,
		OP_PEEK  = 3'd4
	} tss_op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} tss_status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic        push_lo;    // write at the low stack top, bump its count
		logic        push_hi;    // write below the high stack top, bump its count
		logic        pop_lo;     // read low stack top, drop its count
		logic        pop_hi;     // read high stack top, drop its count
		logic        peek;       // read both tops, counts unchanged
		logic        load_imm;   // load a result that needs no store read
		tss_status_t imm_status; // status of that result
		logic        load_rd;    // load the result from the store read
	} tss_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic room;     // both stacks together below capacity
		logic lo_empty; // low stack holds nothing
		logic hi_empty; // high stack holds nothing
	} tss_sts_t;

endpackage

// ===== hw/rtl/two_stacks_shared_array_top.sv =====
// ----------------------------------------------------------------------------
// two_stacks_shared_array_top: two LIFO stacks in one shared store
// Stack one grows up from entry 0, stack two grows down from the top of the
// configured capacity. Push, pop and peek words come in, one result goes out.
//
//   channel  direction  word fields (lowest bit first)
//   s_*      in         op[2:0], value[34:3], zero pad to 40 bits
//   m_*      out        data[31:0], other_top[63:32], status[65:64], pad to 72
//   cfg_*    in         capacity[10:0], written when cfg_we is high
//
// Push, empty pop/peek and unused codes go straight to the result register;
// a pop or peek that reads the store first passes the registered store read.
// A new word is taken while no store read is pending and the result register
// is empty or being taken. A stalled result holds in the output register.
// Reset empties both stacks and sets capacity to 1024 clamped to DEPTH; the
// store itself is not cleared.
// ----------------------------------------------------------------------------
module two_stacks_shared_array_top #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,  // capacity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // op[2:0], value[34:3], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata     // data[31:0], other_top[63:32], status[65:64]
);

	tss_pkg::tss_cmd_t                 cmd;
	tss_pkg::tss_sts_t                 sts;
	logic [tss_pkg::WORD_W-1:0]        data;
	logic [tss_pkg::WORD_W-1:0]        other_top;
	logic [tss_pkg::STATUS_W-1:0]      status;

	tss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (s_tdata[2:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tss_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.value     (s_tdata[34:3]),
		.cmd       (cmd),
		.sts       (sts),
		.data      (data),
		.other_top (other_top),
		.status    (status)
	);

	// Pack the result word
	assign m_tdata = {6'b0, status, other_top, data};

endmodule

// ===== hw/rtl/tss_ram.sv =====
// ----------------------------------------------------------------------------
// tss_ram: generic single-write, dual-read memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module tss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register both reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== hw/rtl/tss_ctrl.sv =====
// ----------------------------------------------------------------------------
// tss_ctrl: operation sequencer for the two-stack store
// Decodes each word, issues datapath commands and owns both handshakes.
// ----------------------------------------------------------------------------
module tss_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [tss_pkg::OP_W-1:0]  op,
	output logic                      out_valid,
	input  logic                      out_ready,
	input  tss_pkg::tss_sts_t         sts,
	output tss_pkg::tss_cmd_t         cmd
);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	// Output register is free when empty or being taken
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Decode the word and pick the next state
	always_comb begin
		cmd            = '0;
		cmd.imm_status = tss_pkg::ST_OK;
		state_nxt      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (tss_pkg::tss_op_t'(op))
						tss_pkg::OP_PUSH1: begin
							cmd.push_lo    = sts.room;
							cmd.load_imm   = 1'b1;
							cmd.imm_status = sts.room ? tss_pkg::ST_OK : tss_pkg::ST_OVERFLOW;
						end
						tss_pkg::OP_PUSH2: begin
							cmd.push_hi    = sts.room;
							cmd.load_imm   = 1'b1;
							cmd.imm_status = sts.room ? tss_pkg::ST_OK : tss_pkg::ST_OVERFLOW;
						end
						tss_pkg::OP_POP1: begin
							if (sts.lo_empty) begin
								cmd.load_imm   = 1'b1;
								cmd.imm_status = tss_pkg::ST_EMPTY;
							end else begin
								cmd.pop_lo = 1'b1;
								state_nxt  = S_READ;
							end
						end
						tss_pkg::OP_POP2: begin
							if (sts.hi_empty) begin
								cmd.load_imm   = 1'b1;
								cmd.imm_status = tss_pkg::ST_EMPTY;
							end else begin
								cmd.pop_hi = 1'b1;
								state_nxt  = S_READ;
							end
						end
						tss_pkg::OP_PEEK: begin
							if (sts.lo_empty || sts.hi_empty) begin
								cmd.load_imm   = 1'b1;
								cmd.imm_status = tss_pkg::ST_EMPTY;
							end else begin
								cmd.peek  = 1'b1;
								state_nxt = S_READ;
							end
						end
						default: begin
							// Unused codes change nothing and report ok
							cmd.load_imm = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				if (out_free) begin
					cmd.load_rd = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_imm || cmd.load_rd) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/tss_dpath.sv =====
// ----------------------------------------------------------------------------
// tss_dpath: counts, capacity, store and result register
// Keeps both stack counts, addresses the shared store and builds each result.
// ----------------------------------------------------------------------------
module tss_dpath #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tss_pkg::CAP_W-1:0]     cfg_wdata,
	input  logic [tss_pkg::WORD_W-1:0]    value,
	input  tss_pkg::tss_cmd_t             cmd,
	output tss_pkg::tss_sts_t             sts,
	output logic [tss_pkg::WORD_W-1:0]    data,
	output logic [tss_pkg::WORD_W-1:0]    other_top,
	output logic [tss_pkg::STATUS_W-1:0]  status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = tss_pkg::CAP_W;
	localparam int WW = tss_pkg::WORD_W;
	localparam logic [CW-1:0] CAP_INIT =
		(DEPTH < tss_pkg::CAP_RESET) ? CW'(DEPTH) : CW'(tss_pkg::CAP_RESET);

	logic [CW-1:0]         cap_q;
	logic [CW-1:0]         cnt_lo_q;
	logic [CW-1:0]         cnt_hi_q;
	logic                  peek_q;
	logic [WW-1:0]         data_q;
	logic [WW-1:0]         other_q;
	logic [1:0]            status_q;
	logic [CW-1:0]         cap_clamped;
	logic [CW-1:0]         lo_top;
	logic [CW-1:0]         hi_top;
	logic [CW-1:0]         hi_new;
	logic [AW-1:0]         waddr;
	logic [AW-1:0]         raddr_a;
	logic                  ram_we;
	logic                  ram_re;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [DATA_WIDTH-1:0] rdata_a;
	logic [DATA_WIDTH-1:0] rdata_b;
	logic [WW-1:0]         word_a;
	logic [WW-1:0]         word_b;

	// Clamp a written capacity to the store depth
	assign cap_clamped = (32'(cfg_wdata) > 32'(DEPTH)) ? CW'(DEPTH) : cfg_wdata;

	// Report room and emptiness
	assign sts.room     = ({1'b0, cnt_lo_q} + {1'b0, cnt_hi_q}) < {1'b0, cap_q};
	assign sts.lo_empty = (cnt_lo_q == '0);
	assign sts.hi_empty = (cnt_hi_q == '0);

	// Entry indexes of both tops and of the next high push
	assign lo_top = cnt_lo_q - CW'(1);
	assign hi_top = cap_q - cnt_hi_q;
	assign hi_new = hi_top - CW'(1);

	// Steer store addresses
	assign ram_we    = cmd.push_lo || cmd.push_hi;
	assign waddr     = cmd.push_lo ? AW'(cnt_lo_q) : AW'(hi_new);
	assign ram_wdata = DATA_WIDTH'(value);
	assign ram_re    = cmd.pop_lo || cmd.pop_hi || cmd.peek;
	assign raddr_a   = cmd.pop_lo ? AW'(lo_top) : AW'(hi_top);

	tss_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr_a (raddr_a),
		.raddr_b (AW'(lo_top)),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Sign-extend narrow entries, keep the low word of wide ones
	if (DATA_WIDTH >= WW) begin : g_wide
		assign word_a = rdata_a[WW-1:0];
		assign word_b = rdata_b[WW-1:0];
	end else begin : g_narrow
		assign word_a = WW'($signed(rdata_a));
		assign word_b = WW'($signed(rdata_b));
	end

	// Advance counts, reload capacity and clear both counts on a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_INIT;
			cnt_lo_q <= '0;
			cnt_hi_q <= '0;
		end else if (cfg_we) begin
			cap_q    <= cap_clamped;
			cnt_lo_q <= '0;
			cnt_hi_q <= '0;
		end else begin
			if (cmd.push_lo) begin
				cnt_lo_q <= cnt_lo_q + CW'(1);
			end else if (cmd.pop_lo) begin
				cnt_lo_q <= lo_top;
			end
			if (cmd.push_hi) begin
				cnt_hi_q <= cnt_hi_q + CW'(1);
			end else if (cmd.pop_hi) begin
				cnt_hi_q <= cnt_hi_q - CW'(1);
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (ram_re) begin
			peek_q <= cmd.peek;
		end
		if (cmd.load_imm) begin
			data_q   <= (cmd.imm_status == tss_pkg::ST_EMPTY) ? '1 : '0;
			other_q  <= '1;
			status_q <= cmd.imm_status;
		end else if (cmd.load_rd) begin
			data_q   <= word_a;
			other_q  <= peek_q ? word_b : '1;
			status_q <= tss_pkg::ST_OK;
		end
	end

	assign data      = data_q;
	assign other_top = other_q;
	assign status    = status_q;

endmodule

// ===== sim/two_stacks_shared_array_top_tb.sv =====
// ----------------------------------------------------------------------------
// two_stacks_shared_array_top_tb: self-checking bench for the two-stack store
// Streams push, pop, peek and unused op codes into the block and compares
// every result word against an in-bench model of both stacks. The run starts
// with a short directed sequence, then goes through random phases at
// several capacities. Input gaps and output stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module two_stacks_shared_array_top_tb;

	localparam int MEM_DEPTH   = 1024;
	localparam int MEM_AW      = $clog2(MEM_DEPTH);
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_PHASES  = 9;

	typedef logic [tss_pkg::OP_W-1:0] op_bits_t;
	typedef logic [MEM_AW-1:0]        mem_idx_t;

	// One input word: op in the low bits, value above it
	typedef struct packed {
		logic [tss_pkg::WORD_W-1:0] value;
		logic [tss_pkg::OP_W-1:0]   op;
	} stack_word_t;

	typedef struct {
		logic [tss_pkg::WORD_W-1:0] data;
		logic [tss_pkg::WORD_W-1:0] other_top;
		tss_pkg::tss_status_t       status;
	} stack_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [10:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [71:0] m_tdata;

	// Stack model state
	logic [tss_pkg::WORD_W-1:0] model_mem [MEM_DEPTH];
	int                         model_lo_cnt;
	int                         model_hi_cnt;
	int                         model_capacity;

	stack_word_t   pending_words [$];
	stack_result_t expected_results [$];
	stack_result_t exp_res;

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int err_cnt         = 0;
	int cycles          = 0;
	int n_words         = 0;
	int n_ok            = 0;
	int n_overflow      = 0;
	int n_empty         = 0;
	int n_cap_writes    = 0;

	// Random phase plan: capacity, sender gap, receiver stall, word count, push share
	int phase_cap   [NUM_PHASES] = '{2047, 1, 2, 7, 16, 0, 1024, 1025, 3};
	int phase_idle  [NUM_PHASES] = '{0, 46, 0, 19, 0, 19, 46, 0, 19};
	int phase_stall [NUM_PHASES] = '{0, 0, 46, 19, 0, 19, 0, 46, 19};
	int phase_words [NUM_PHASES] = '{150, 100, 120, 150, 150, 40, 150, 150, 140};
	int phase_push  [NUM_PHASES] = '{50, 50, 55, 60, 55, 50, 60, 50, 55};

	two_stacks_shared_array_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Free-running clock
	initial begin
		forever #6 clk = ~clk;
	end

	// Apply one word to the stack model and return the result it should produce
	function automatic stack_result_t predict_stack_op(stack_word_t w);
		stack_result_t r;
		int            ecap;
		logic          room;
		ecap = (model_capacity > MEM_DEPTH) ? MEM_DEPTH : model_capacity;
		r.data = '0;
		r.other_top = '1;
		r.status = tss_pkg::ST_OK;
		room = (model_lo_cnt + model_hi_cnt) < ecap;
		case (w.op)
			tss_pkg::OP_PUSH1, tss_pkg::OP_PUSH2: begin
				if (!room) begin
					r.status = tss_pkg::ST_OVERFLOW;
				end else if (w.op == tss_pkg::OP_PUSH1) begin
					model_mem[mem_idx_t'(model_lo_cnt)] = w.value;
					model_lo_cnt++;
				end else begin
					model_hi_cnt++;
					model_mem[mem_idx_t'(ecap - model_hi_cnt)] = w.value;
				end
			end
			tss_pkg::OP_POP1: begin
				if (model_lo_cnt == 0) begin
					r.data = '1;
					r.status = tss_pkg::ST_EMPTY;
				end else begin
					model_lo_cnt--;
					r.data = model_mem[mem_idx_t'(model_lo_cnt)];
				end
			end
			tss_pkg::OP_POP2: begin
				if (model_hi_cnt == 0) begin
					r.data = '1;
					r.status = tss_pkg::ST_EMPTY;
				end else begin
					r.data = model_mem[mem_idx_t'(ecap - model_hi_cnt)];
					model_hi_cnt--;
				end
			end
			tss_pkg::OP_PEEK: begin
				if (model_lo_cnt == 0 || model_hi_cnt == 0) begin
					r.data = '1;
					r.status = tss_pkg::ST_EMPTY;
				end else begin
					r.data = model_mem[mem_idx_t'(ecap - model_hi_cnt)];
					r.other_top = model_mem[mem_idx_t'(model_lo_cnt - 1)];
				end
			end
			default: begin
				// unused codes leave the stacks alone
			end
		endcase
		n_words++;
		case (r.status)
			tss_pkg::ST_OVERFLOW: n_overflow++;
			tss_pkg::ST_EMPTY:    n_empty++;
			default:              n_ok++;
		endcase
		return r;
	endfunction

	// Pick a random word, biased toward pushes by push_pct
	function automatic stack_word_t random_word(int push_pct);
		stack_word_t w;
		int          r;
		r = $urandom_range(99);
		if (r < 4) begin
			w.op = op_bits_t'($urandom_range(7, 5));
		end else if (r < 4 + push_pct) begin
			w.op = $urandom_range(1) ? tss_pkg::OP_PUSH2 : tss_pkg::OP_PUSH1;
		end else begin
			r = $urandom_range(99);
			w.op = (r < 40) ? tss_pkg::OP_POP1 : (r < 80) ? tss_pkg::OP_POP2 : tss_pkg::OP_PEEK;
		end
		case ($urandom_range(15))
			0:       w.value = 32'h7fff_ffff;
			1:       w.value = 32'h8000_0000;
			2:       w.value = '0;
			3:       w.value = '1;
			default: w.value = $urandom;
		endcase
		return w;
	endfunction

	task automatic add_word(input logic [tss_pkg::OP_W-1:0] op,
		input logic [tss_pkg::WORD_W-1:0] value);
		stack_word_t w;
		w.op = op;
		w.value = value;
		pending_words.push_back(w);
	endtask

	// Hold until every queued word went in and every result came back
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write capacity while idle; the write also empties both stacks
	task automatic write_capacity(input logic [10:0] cap);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_capacity = int'(cap);
		model_lo_cnt = 0;
		model_hi_cnt = 0;
		n_cap_writes++;
	endtask

	// Input driver: predict the accepted word, then present the next one
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (s_tvalid)
				expected_results.push_back(predict_stack_op(stack_word_t'(s_tdata[34:0])));
			if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= {5'b0, pending_words.pop_front()};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output stall pattern
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Result monitor: compare each taken word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result word %h", m_tdata);
				err_cnt++;
			end else begin
				exp_res = expected_results.pop_front();
				if (m_tdata[31:0] !== exp_res.data) begin
					$error("data: expected %h, got %h", exp_res.data, m_tdata[31:0]);
					err_cnt++;
				end
				if (m_tdata[63:32] !== exp_res.other_top) begin
					$error("other_top: expected %h, got %h", exp_res.other_top,
						m_tdata[63:32]);
					err_cnt++;
				end
				if (m_tdata[65:64] !== exp_res.status) begin
					$error("status: expected %0d, got %0d", exp_res.status, m_tdata[65:64]);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Test sequence
	initial begin
		model_capacity = tss_pkg::CAP_RESET;
		model_lo_cnt = 0;
		model_hi_cnt = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every op, empty and one-sided peek, unused codes
		add_word(tss_pkg::OP_PUSH1, 32'h7fff_ffff);
		add_word(tss_pkg::OP_PUSH2, 32'h8000_0000);
		add_word(tss_pkg::OP_PEEK, $urandom);
		add_word(tss_pkg::OP_PUSH1, 32'hffff_ffff);
		add_word(tss_pkg::OP_PUSH2, 32'h0000_0000);
		add_word(tss_pkg::OP_POP1, $urandom);
		add_word(tss_pkg::OP_POP2, $urandom);
		add_word(tss_pkg::OP_POP1, $urandom);
		add_word(tss_pkg::OP_POP2, $urandom);
		add_word(tss_pkg::OP_POP1, $urandom);
		add_word(tss_pkg::OP_POP2, $urandom);
		add_word(tss_pkg::OP_PEEK, $urandom);
		add_word(tss_pkg::OP_PUSH1, 32'd5);
		add_word(tss_pkg::OP_PEEK, $urandom);
		add_word(3'd5, $urandom);
		add_word(3'd6, $urandom);
		add_word(3'd7, $urandom);
		wait_drained();

		// Single-entry store, written while stack one is not empty
		write_capacity(11'd1);
		add_word(tss_pkg::OP_PUSH1, 32'h1234_5678);
		add_word(tss_pkg::OP_PUSH2, 32'h8765_4321);
		add_word(tss_pkg::OP_POP2, $urandom);
		add_word(tss_pkg::OP_PEEK, $urandom);
		wait_drained();

		// Zero capacity: nothing fits, nothing to pop
		write_capacity(11'd0);
		add_word(tss_pkg::OP_POP1, $urandom);
		add_word(tss_pkg::OP_PUSH2, $urandom);
		add_word(tss_pkg::OP_PUSH1, $urandom);
		wait_drained();

		// Random phases
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_capacity(11'(phase_cap[p]));
			sender_idle_pct = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			for (int i = 0; i < phase_words[p]; i++) begin
				// hold the sender once mid-phase until all results are back
				if (p == 4 && i == phase_words[p] / 2)
					wait_drained();
				pending_words.push_back(random_word(phase_push[p]));
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		$display("covered %0d words over %0d capacity writes, reset capacity included",
			n_words, n_cap_writes);
		$display("results: %0d ok, %0d overflow, %0d empty", n_ok, n_overflow, n_empty);
		if (err_cnt == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
